// ===== rtl/dq_pkg.sv =====
// dq_pkg: shared widths, defaults and operation/status codes for the deque
// no dependencies; imported by the deque top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // defaults for the top-level parameters
  localparam int DEPTH_DEFAULT      = 256;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // fixed port field widths
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int RDATA_W  = 32;
  localparam int OCC_W    = 9;
  localparam int STATUS_W = 2;

  // operation codes; the two spare codes are no-ops
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_READ_INDEX = 3'd2,
    ACT_READ_FRONT = 3'd3,
    ACT_READ_BACK  = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_FULL_DROP  = 2'd2,
    ST_EMPTY_READ = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue_top.sv =====
// double_ended_queue_top: bounded deque held in a ring buffer in one
// synchronous memory, with a front pointer and an entry count
// depends on dq_pkg
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+--------------------------
//  operation | action, value, index                   | start high, busy low
//  result    | read_data, occupancy, is_empty, status | done high for one cycle
//
// one word is taken every cycle; its result shows in the cycle after acceptance,
// set by the registered read port of the entry memory
// busy stays low: pointer and count are updated at the accepting edge, and the
// memory write of a push lands before any following read can be issued
// reset clears pointer, count and the result strobe; memory contents are left
// as they are and are never returned before a push has written them
// the receiver cannot stall, so nothing is held back on the result side
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [dq_pkg::ACTION_W-1:0]  action,
  input  wire logic [dq_pkg::VALUE_W-1:0]   value,
  input  wire logic [dq_pkg::INDEX_W-1:0]   index,
  output logic                              done,
  output logic [dq_pkg::RDATA_W-1:0]        read_data,
  output logic [dq_pkg::OCC_W-1:0]          occupancy,
  output logic                              is_empty,
  output logic [dq_pkg::STATUS_W-1:0]       status
);

  import dq_pkg::*;

  // pointer indexes a slot, count must also hold DEPTH itself
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // positions are compared at the wider of the index field and the count
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  // front plus position before the wrap
  localparam int SUM_W = PTR_W + 1;

  // entry memory, one port, registered read
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  // ring state
  logic [PTR_W-1:0] front;
  logic [CNT_W-1:0] count;

  // result registers
  logic             read_ok;
  logic [OCC_W-1:0] occ_q;
  logic             empty_q;
  status_t          status_q;

  // next-state and per-operation decode
  logic             accept;
  action_t          act;
  logic             full;
  logic             empty_now;
  logic [PTR_W-1:0] front_dec;
  logic [CMP_W-1:0] pos;
  logic [SUM_W-1:0] sum;
  logic [PTR_W-1:0] ring_slot;
  logic [PTR_W-1:0] slot;
  logic             wr_en;
  logic             rd_en;
  logic [PTR_W-1:0] front_next;
  logic [CNT_W-1:0] count_next;
  status_t          status_next;

  // the ring never needs to hold off a new word
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign act    = action_t'(action);

  assign full      = (count == CNT_W'(DEPTH));
  assign empty_now = (count == '0);
  assign front_dec = (front == '0) ? PTR_W'(DEPTH - 1) : front - 1'b1;

  // position from the front that the operation touches
  always_comb begin
    case (act)
      ACT_PUSH_BACK:  pos = CMP_W'(count);
      ACT_READ_FRONT: pos = '0;
      ACT_READ_BACK:  pos = CMP_W'(CNT_W'(count - 1'b1));
      default:        pos = CMP_W'(index);
    endcase
  end

  // slot of that position, wrapping past the end of the ring
  always_comb begin
    sum = SUM_W'(front) + SUM_W'(pos);
    if (sum >= SUM_W'(DEPTH)) begin
      ring_slot = PTR_W'(sum - SUM_W'(DEPTH));
    end else begin
      ring_slot = PTR_W'(sum);
    end
  end

  assign slot = (act == ACT_PUSH_FRONT) ? front_dec : ring_slot;

  // operation decode
  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = ST_OK;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL_DROP;
        end else begin
          front_next = front_dec;
          count_next = count + 1'b1;
          wr_en      = 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL_DROP;
        end else begin
          count_next = count + 1'b1;
          wr_en      = 1'b1;
        end
      end
      ACT_READ_INDEX, ACT_READ_FRONT, ACT_READ_BACK: begin
        // an empty queue outranks the range check
        if (empty_now) begin
          status_next = ST_EMPTY_READ;
        end else if (pos >= CMP_W'(count)) begin
          status_next = ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      ACT_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
        // spare codes leave everything as it is
      end
    endcase
  end

  // memory port: a push writes its slot, a read fetches it for the next cycle
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[slot] <= DATA_WIDTH'(value);
    end
    if (accept) begin
      rd_q <= mem[slot];
    end
  end

  // ring state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  // result payload needs no reset, it is qualified by done
  always_ff @(posedge clk) begin
    if (accept) begin
      read_ok  <= rd_en;
      occ_q    <= OCC_W'(count_next);
      empty_q  <= (count_next == '0);
      status_q <= status_next;
    end
  end

  // failed reads and non-read operations return zero data
  assign read_data = read_ok ? RDATA_W'(rd_q) : '0;
  assign occupancy = occ_q;
  assign is_empty  = empty_q;
  assign status    = status_q;

endmodule

`default_nettype wire

// ===== rtl/dq_checker.sv =====
// dq_checker: port-level checks on the deque result stream
// depends on dq_pkg; bound to double_ended_queue_top below
`timescale 1ns / 1ps
`default_nettype none

module dq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [dq_pkg::RDATA_W-1:0]  read_data,
  input wire logic [dq_pkg::OCC_W-1:0]    occupancy,
  input wire logic                        is_empty,
  input wire logic [dq_pkg::STATUS_W-1:0] status
);

  import dq_pkg::*;

  // exactly one result, in the cycle after each accepted word
  a_done_follows: assert property (@(posedge clk)
    (!rst && $past(!rst)) |-> (done == $past(start && !busy)))
    else $error("result strobe does not match accepted word");

  // empty flag agrees with the reported occupancy
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (occupancy == '0)))
    else $error("empty flag and occupancy disagree");

  // only a successful operation may carry data
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (read_data == '0))
    else $error("failed operation returned data");

  // a dropped push can only happen with entries present
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL_DROP)) |-> !is_empty)
    else $error("full drop reported on an empty queue");

  // an empty read leaves the queue empty
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY_READ)) |-> is_empty)
    else $error("empty read reported with entries present");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for double_ended_queue_top, directed words then random segments
// depends on dq_pkg and the deque top level; carries its own mirror of the ring buffer

module tb;
  import dq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_WORDS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RESET_CYCLES = 7;

  // the two spare action codes, which the block treats as no-ops
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    logic [INDEX_W-1:0]  idx;
  } deque_op_t;

  typedef struct packed {
    logic [RDATA_W-1:0] rdata;
    logic [OCC_W-1:0]   occ;
    logic               empty;
    status_t            st;
  } deque_result_t;

  // block inputs, all known from time zero
  logic                clk    = 1'b0;
  logic                rst    = 1'b1;
  logic                start  = 1'b0;
  logic [ACTION_W-1:0] action = '0;
  logic [VALUE_W-1:0]  value  = '0;
  logic [INDEX_W-1:0]  index  = '0;

  // block outputs
  logic                busy;
  logic                done;
  logic [RDATA_W-1:0]  read_data;
  logic [OCC_W-1:0]    occupancy;
  logic                is_empty;
  logic [STATUS_W-1:0] status;

  // words waiting to be driven, and results waiting to arrive
  deque_op_t     pending_words[$];
  deque_result_t expected_results[$];

  // generator view of the fill level, so sequences can aim at the full store
  int gen_count = 0;
  int gen_words = 0;

  // mirror of the ring buffer
  logic [RDATA_W-1:0] mirror_store [DEPTH];
  int mirror_front   = 0;
  int mirror_count   = 0;
  int peak_occupancy = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  // driver and monitor bookkeeping
  logic          word_taken = 1'b0;
  int            burst_left = 0;
  int            gap_left   = 0;
  deque_op_t     next_op;
  deque_op_t     taken_op;
  deque_result_t want;
  deque_result_t predicted;
  int            words_sent      = 0;
  int            results_checked = 0;
  int            error_count     = 0;
  int            cycle_count     = 0;

  double_ended_queue_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .value     (value),
    .index     (index),
    .done      (done),
    .read_data (read_data),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .status    (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d, result %0d: %s", cycle_count, results_checked, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // mirror of the block
  // ---------------------------------------------------------------------------

  // slot holding a position counted from the front, with wrap-around
  function automatic int slot_at(input int pos);
    return (mirror_front + pos) % DEPTH;
  endfunction

  task automatic predict_result(input deque_op_t op, output deque_result_t r);
    int pos;
    r.rdata = '0;
    r.st    = ST_OK;
    pos     = 0;
    case (op.act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          // full store: word dropped, nothing moves
          r.st = ST_FULL_DROP;
        end else if (op.act == ACT_PUSH_FRONT) begin
          mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
          mirror_store[mirror_front] = op.val;
          mirror_count++;
        end else begin
          mirror_store[slot_at(mirror_count)] = op.val;
          mirror_count++;
        end
      end
      ACT_READ_INDEX, ACT_READ_FRONT, ACT_READ_BACK: begin
        // an empty queue wins over the index check
        if (mirror_count == 0) begin
          r.st = ST_EMPTY_READ;
        end else begin
          if (op.act == ACT_READ_FRONT) pos = 0;
          else if (op.act == ACT_READ_BACK) pos = mirror_count - 1;
          else pos = int'(op.idx);
          if (pos >= mirror_count) r.st = ST_RANGE;
          else r.rdata = mirror_store[slot_at(pos)];
        end
      end
      ACT_CLEAR: begin
        mirror_count = 0;
        mirror_front = 0;
      end
      default: ;
    endcase
    r.occ   = OCC_W'(mirror_count);
    r.empty = (mirror_count == 0);
    status_tally[r.st]++;
    if (mirror_count > peak_occupancy) peak_occupancy = mirror_count;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                            input logic [INDEX_W-1:0] idx);
    deque_op_t op;
    op.act = act;
    op.val = val;
    op.idx = idx;
    pending_words.insert(pending_words.size(), op);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: if (gen_count < DEPTH) gen_count++;
      ACT_CLEAR: gen_count = 0;
      default: ;
    endcase
    gen_words++;
  endtask

  // mostly inside the stored range, now and then anywhere
  function automatic logic [INDEX_W-1:0] pick_index();
    logic [INDEX_W-1:0] r;
    if (gen_count > 0 && $urandom_range(0, 3) != 0) r = INDEX_W'($urandom_range(0, gen_count - 1));
    else r = INDEX_W'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic queue_random_push();
    queue_word($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom,
               INDEX_W'($urandom));
  endtask

  task automatic queue_random_read();
    case ($urandom_range(0, 2))
      0: queue_word(ACT_READ_INDEX, $urandom, pick_index());
      1: queue_word(ACT_READ_FRONT, $urandom, INDEX_W'($urandom));
      default: queue_word(ACT_READ_BACK, $urandom, INDEX_W'($urandom));
    endcase
  endtask

  // push until the store is full, reading along the way, then try a few dropped pushes
  task automatic fill_to_full();
    int extra;
    if ($urandom_range(0, 1)) queue_word(ACT_CLEAR, $urandom, INDEX_W'($urandom));
    while (gen_count < DEPTH) begin
      if ($urandom_range(0, 9) < 7) queue_random_push();
      else queue_random_read();
    end
    extra = $urandom_range(2, 6);
    repeat (extra) begin
      queue_random_push();
      queue_random_read();
    end
    // last position of a full store
    queue_word(ACT_READ_INDEX, $urandom, 8'hFF);
  endtask

  initial begin
    int base;
    int segment;
    int len;
    int pick;

    // directed: every read on an empty queue, clear and spare codes while empty
    queue_word(ACT_READ_FRONT, 32'h0, 8'h00);
    queue_word(ACT_READ_BACK,  32'h0, 8'h00);
    queue_word(ACT_READ_INDEX, 32'h0, 8'h00);
    queue_word(ACT_READ_INDEX, 32'hFFFF_FFFF, 8'hFF);
    queue_word(ACT_CLEAR,      32'h0, 8'h00);
    queue_word(ACT_SPARE_LO,   32'h0, 8'h00);
    queue_word(ACT_SPARE_HI,   32'hFFFF_FFFF, 8'hFF);
    // push front from pointer zero wraps to the top slot
    queue_word(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 8'h00);
    queue_word(ACT_PUSH_BACK,  32'h0000_0000, 8'hFF);
    queue_word(ACT_PUSH_FRONT, 32'hA5A5_5A5A, 8'h00);
    queue_word(ACT_PUSH_BACK,  32'h0000_0001, 8'h00);
    queue_word(ACT_READ_FRONT, 32'h0, 8'h00);
    queue_word(ACT_READ_BACK,  32'h0, 8'h00);
    queue_word(ACT_READ_INDEX, 32'h0, 8'h00);
    queue_word(ACT_READ_INDEX, 32'h0, 8'h01);
    queue_word(ACT_READ_INDEX, 32'h0, 8'h02);
    queue_word(ACT_READ_INDEX, 32'h0, 8'h03);
    // index at and well past the occupancy
    queue_word(ACT_READ_INDEX, 32'h0, 8'h04);
    queue_word(ACT_READ_INDEX, 32'h0, 8'hFF);
    // spare codes with data in the store leave it alone
    queue_word(ACT_SPARE_LO,   32'hFFFF_FFFF, 8'h01);
    queue_word(ACT_SPARE_HI,   32'h1234_5678, 8'h00);
    queue_word(ACT_READ_BACK,  32'h0, 8'h00);
    queue_word(ACT_CLEAR,      32'hFFFF_FFFF, 8'hFF);
    queue_word(ACT_READ_FRONT, 32'h0, 8'h00);
    queue_word(ACT_PUSH_BACK,  32'h8000_0000, 8'h00);
    queue_word(ACT_READ_INDEX, 32'h0, 8'h00);

    // random: fill-to-full segments among short mixed ones, until the word budget is reached
    base    = gen_words;
    segment = 0;
    while (gen_words - base < RANDOM_WORDS) begin
      if (segment == 0 ||
          ($urandom_range(0, 7) == 0 && RANDOM_WORDS - (gen_words - base) > DEPTH)) begin
        fill_to_full();
      end else begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          pick = $urandom_range(0, 19);
          if (pick < 8) queue_random_push();
          else if (pick < 17) queue_random_read();
          else if (pick == 17) queue_word(ACT_CLEAR, $urandom, INDEX_W'($urandom));
          else queue_word(pick == 18 ? ACT_SPARE_LO : ACT_SPARE_HI, $urandom,
                          INDEX_W'($urandom));
        end
      end
      segment++;
    end

    // single reset at the start, released on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every word to go in and every result to come back
    while (pending_words.size() != 0 || start || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words driven, %0d results checked, peak occupancy %0d of %0d",
             words_sent, results_checked, peak_occupancy, DEPTH);
    $display("status seen: ok %0d, out of range %0d, full drop %0d, empty read %0d",
             status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_FULL_DROP],
             status_tally[ST_EMPTY_READ]);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: changes inputs on the falling edge, bursts with random gaps
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_words.size() != 0) begin
        next_op = pending_words.pop_front();
        start  <= 1'b1;
        action <= next_op.act;
        value  <= next_op.val;
        index  <= next_op.idx;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // new burst; a quarter of them run straight on with no gap
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples on the rising edge, checks results, predicts accepted words
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    word_taken <= start && !busy && !rst;
    if (!rst) begin
      // check first, so a word taken on this edge queues behind older results
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no word outstanding, read_data %h", read_data));
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.rdata)
            report_mismatch($sformatf("read_data got %h want %h", read_data, want.rdata));
          if (occupancy !== want.occ)
            report_mismatch($sformatf("occupancy got %0d want %0d", occupancy, want.occ));
          if (is_empty !== want.empty)
            report_mismatch($sformatf("is_empty got %b want %b", is_empty, want.empty));
          if (status !== want.st)
            report_mismatch($sformatf("status got %0d want %0d", status, want.st));
          results_checked++;
        end
      end
      if (start && !busy) begin
        taken_op.act = action;
        taken_op.val = value;
        taken_op.idx = index;
        predict_result(taken_op, predicted);
        expected_results.insert(expected_results.size(), predicted);
        words_sent++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
